FILE: sv/cfpu_pkg.sv
// cfpu_pkg: shared types and constants of the command frame parser unit
// no dependencies; used by every module of the unit
package cfpu_pkg;

  // frame bytes
  localparam logic [7:0] HDR_FIRST      = 8'hAA;
  localparam logic [7:0] HDR_SECOND     = 8'hAF;
  localparam logic [7:0] FN_COMMAND     = 8'h02;
  localparam logic [7:0] CMD_READBACK   = 8'h01;
  localparam logic [7:0] CMD_VERSION    = 8'hA0;
  localparam logic [7:0] FN_ACK_LOW     = 8'h10;
  localparam logic [7:0] FN_ACK_HIGH    = 8'h15;

  // acknowledge frame bytes
  localparam logic [7:0] ACK_HDR        = 8'hAA;
  localparam logic [7:0] ACK_ID         = 8'hEF;
  localparam logic [7:0] ACK_LEN        = 8'h02;
  // sum of AA AA EF 02, mod 256
  localparam logic [7:0] ACK_SUM_BASE   = 8'h45;
  localparam logic [2:0] ACK_LAST_IDX   = 3'd6;

  // register reset values
  localparam logic [7:0] LENGTH_LIMIT_RST   = 8'd50;
  localparam logic [7:0] FUNCTION_LIMIT_RST = 8'hF1;

  // register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_LIMIT   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_FUNCTION_LIMIT = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_ACK_BYTE = 2'd0;
  localparam logic [1:0] KIND_VERSION  = 2'd1;
  localparam logic [1:0] KIND_READBACK = 2'd2;

  typedef enum logic [1:0] {
    OP_ACK,
    OP_VERSION,
    OP_READBACK
  } cmd_op_e;

  // one queued action, handed from the parser to the emitter
  typedef struct packed {
    cmd_op_e    op;
    logic [7:0] fn;
    logic [7:0] sum;
  } cmd_t;

endpackage

FILE: sv/cfpu_rx_if.sv
// cfpu_rx_if: valid/ready channel carrying one received link byte
// no dependencies
interface cfpu_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/cfpu_tx_if.sv
// cfpu_tx_if: valid/ready channel carrying one parser result
// no dependencies
interface cfpu_tx_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] tx_byte;
  logic       last;

  modport source (output valid, output kind, output tx_byte, output last, input ready);
  modport sink   (input valid, input kind, input tx_byte, input last, output ready);
endinterface

FILE: sv/command_frame_parser_unit.sv
// command_frame_parser_unit: top level of the command frame parser
// depends on cfpu_pkg, cfpu_rx_if, cfpu_tx_if, cfpu_front, cfpu_cmd_fifo, cfpu_back
//
//   channel  dir  handshake     payload
//   rx_i     in   valid/ready   rx_byte[7:0]
//   tx_o     out  valid/ready   kind[1:0], tx_byte[7:0], last
//   cfg      in   cfg_we_i      cfg_idx_i (0 length limit, 1 function limit), cfg_data_i[7:0]
//
// the parser takes one byte per cycle whenever the action queue has room
// an ack is seven results, a request one; the emitter sets the sustained rate
// a good frame's action is queued as its checksum is taken, then offered by the emitter
// output stalls back up into the queue only; the parser keeps running until it fills
// asynchronous active-low reset returns to hunting with limits 50 and 241
module command_frame_parser_unit #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfpu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                     cfg_data_i,
  cfpu_rx_if.sink                        rx_i,
  cfpu_tx_if.source                      tx_o
);

  // queue handshake between parser and emitter
  logic           q_push, q_full, q_pop, q_empty;
  cfpu_pkg::cmd_t q_push_cmd, q_head;

  // front: header hunt, length and payload tracking, checksum compare
  cfpu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (rx_i.valid),
    .in_ready_o (rx_i.ready),
    .in_byte_i  (rx_i.rx_byte),
    .q_full_i   (q_full),
    .push_o     (q_push),
    .push_cmd_o (q_push_cmd)
  );

  // decoupling queue of pending actions
  cfpu_cmd_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_cmd_i (q_push_cmd),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  // back: walks an action out as one or seven result transactions
  cfpu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_head_i    (q_head),
    .pop_o       (q_pop),
    .out_valid_o (tx_o.valid),
    .out_ready_i (tx_o.ready),
    .out_kind_o  (tx_o.kind),
    .out_byte_o  (tx_o.tx_byte),
    .out_last_o  (tx_o.last)
  );

endmodule

FILE: sv/cfpu_front.sv
// cfpu_front: frame parser and checksum check, pushes actions into the queue
// depends on cfpu_pkg
module cfpu_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [cfpu_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [7:0]                    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    in_byte_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output cfpu_pkg::cmd_t                push_cmd_o
);

  typedef enum logic [2:0] {
    PH_HUNT,
    PH_HDR2,
    PH_FUNC,
    PH_LEN,
    PH_PAYLOAD,
    PH_CSUM
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] left_q, left_d;
  logic [7:0] sum_q, sum_d;
  logic [7:0] fn_q, fn_d;
  logic [7:0] cmd_q, cmd_d;
  logic       seen_q, seen_d;
  logic [7:0] len_lim_q, fn_lim_q;

  logic       accept;
  logic [7:0] b;
  logic [7:0] cmd_eff;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign b          = in_byte_i;
  assign cmd_eff    = seen_q ? cmd_q : b;

  always_comb begin
    phase_d    = phase_q;
    left_d     = left_q;
    sum_d      = sum_q;
    fn_d       = fn_q;
    cmd_d      = cmd_q;
    seen_d     = seen_q;
    push_o     = 1'b0;
    push_cmd_o = '{op: cfpu_pkg::OP_ACK, fn: fn_q, sum: sum_q};
    if (accept) begin
      phase_d = PH_HUNT;
      case (phase_q)
        PH_HUNT: begin
          if (b == cfpu_pkg::HDR_FIRST) begin
            phase_d = PH_HDR2;
            sum_d   = b;
            seen_d  = 1'b0;
            cmd_d   = 8'h00;
          end
        end
        PH_HDR2: begin
          if (b == cfpu_pkg::HDR_SECOND) begin
            phase_d = PH_FUNC;
            sum_d   = sum_q + b;
          end
        end
        PH_FUNC: begin
          if (b < fn_lim_q) begin
            phase_d = PH_LEN;
            fn_d    = b;
            sum_d   = sum_q + b;
          end
        end
        PH_LEN: begin
          if (b < len_lim_q) begin
            sum_d   = sum_q + b;
            left_d  = b;
            phase_d = (b == 8'h00) ? PH_CSUM : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (left_q != 8'h00) begin
            if (!seen_q) begin
              cmd_d  = b;
              seen_d = 1'b1;
            end
            sum_d   = sum_q + b;
            left_d  = left_q - 8'd1;
            phase_d = (left_q == 8'd1) ? PH_CSUM : PH_PAYLOAD;
          end
        end
        PH_CSUM: begin
          cmd_d  = cmd_eff;
          seen_d = 1'b1;
          if (sum_q == b) begin
            if (fn_q == cfpu_pkg::FN_COMMAND) begin
              if (cmd_eff == cfpu_pkg::CMD_READBACK) begin
                push_o        = 1'b1;
                push_cmd_o.op = cfpu_pkg::OP_READBACK;
              end else if (cmd_eff == cfpu_pkg::CMD_VERSION) begin
                push_o        = 1'b1;
                push_cmd_o.op = cfpu_pkg::OP_VERSION;
              end
            end else if (fn_q inside {[cfpu_pkg::FN_ACK_LOW:cfpu_pkg::FN_ACK_HIGH]}) begin
              push_o        = 1'b1;
              push_cmd_o.op = cfpu_pkg::OP_ACK;
            end
          end
        end
        default: phase_d = PH_HUNT;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HUNT;
      left_q    <= 8'h00;
      sum_q     <= 8'h00;
      fn_q      <= 8'h00;
      cmd_q     <= 8'h00;
      seen_q    <= 1'b0;
      len_lim_q <= cfpu_pkg::LENGTH_LIMIT_RST;
      fn_lim_q  <= cfpu_pkg::FUNCTION_LIMIT_RST;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      fn_q    <= fn_d;
      cmd_q   <= cmd_d;
      seen_q  <= seen_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfpu_pkg::CFG_LENGTH_LIMIT:   len_lim_q <= cfg_data_i;
          cfpu_pkg::CFG_FUNCTION_LIMIT: fn_lim_q  <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

endmodule

FILE: sv/cfpu_cmd_fifo.sv
// cfpu_cmd_fifo: short action queue between the parser and the emitter
// depends on cfpu_pkg
module cfpu_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  cfpu_pkg::cmd_t push_cmd_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output cfpu_pkg::cmd_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cfpu_pkg::cmd_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

FILE: sv/cfpu_back.sv
// cfpu_back: emitter that turns queued actions into result transactions
// depends on cfpu_pkg
module cfpu_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_empty_i,
  input  cfpu_pkg::cmd_t q_head_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [1:0]     out_kind_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);

  logic           busy_q;
  logic [2:0]     idx_q;
  cfpu_pkg::cmd_t cmd_q;
  logic           fire;

  assign out_valid_o = busy_q;
  assign fire        = busy_q && out_ready_i;
  assign pop_o       = !q_empty_i && (!busy_q || (fire && out_last_o));

  always_comb begin
    out_kind_o = cfpu_pkg::KIND_ACK_BYTE;
    out_byte_o = 8'h00;
    out_last_o = 1'b1;
    case (cmd_q.op)
      cfpu_pkg::OP_VERSION:  out_kind_o = cfpu_pkg::KIND_VERSION;
      cfpu_pkg::OP_READBACK: out_kind_o = cfpu_pkg::KIND_READBACK;
      cfpu_pkg::OP_ACK: begin
        out_last_o = (idx_q == cfpu_pkg::ACK_LAST_IDX);
        case (idx_q)
          3'd0, 3'd1: out_byte_o = cfpu_pkg::ACK_HDR;
          3'd2:       out_byte_o = cfpu_pkg::ACK_ID;
          3'd3:       out_byte_o = cfpu_pkg::ACK_LEN;
          3'd4:       out_byte_o = cmd_q.fn;
          3'd5:       out_byte_o = cmd_q.sum;
          3'd6:       out_byte_o = cfpu_pkg::ACK_SUM_BASE + cmd_q.fn + cmd_q.sum;
          default:    out_byte_o = 8'h00;
        endcase
      end
      default: out_kind_o = cfpu_pkg::KIND_ACK_BYTE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= 3'd0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        idx_q  <= 3'd0;
      end else if (fire) begin
        if (out_last_o) begin
          busy_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q <= q_head_i;
    end
  end

endmodule

FILE: tb/tb_command_frame_parser_unit.sv
// tb_command_frame_parser_unit: self-checking bench for the command frame parser unit
// sends framed link bytes with random stalls and checks every result against a local parser
// depends on cfpu_pkg, cfpu_rx_if, cfpu_tx_if and command_frame_parser_unit
module tb_command_frame_parser_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WATCHDOG_LIMIT  = 2000;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned SETTLE_CYCLES   = 8;
  localparam int unsigned BURST_BYTES     = 12;
  localparam int unsigned PRESSURE_FRAMES = 5;
  localparam int unsigned MAX_REPORTS     = 10;
  localparam int unsigned TABLE_ROWS      = 25;

  // parse phases of the local frame parser
  typedef enum logic [2:0] {
    PH_HUNT,
    PH_SYNC,
    PH_FUNC,
    PH_LEN,
    PH_PAYLOAD,
    PH_CHECK
  } parse_phase_e;

  // one result transaction on tx_o
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] tx_byte;
    logic       last;
  } tx_item_t;

  // one directed row: the byte, and where obvious the results it must cause
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       typed;
    logic [2:0] n_res;
    logic [1:0] kind;
  } frame_row_t;

  localparam frame_row_t FRAME_TABLE [TABLE_ROWS] = '{
    // line noise at hunt, then a first header followed by another first header
    '{8'hFF, 1'b1, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hAA, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hAA, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    // parameter readback request, checksum 0x5d
    '{8'hAA, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hAF, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h02, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h01, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h01, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h5D, 1'b1, 3'd1, cfpu_pkg::KIND_READBACK},
    // version request, checksum 0xfc
    '{8'hAA, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hAF, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h02, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h01, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hA0, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hFC, 1'b1, 3'd1, cfpu_pkg::KIND_VERSION},
    // zero-length acknowledge frame, highest ack function
    '{8'hAA, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hAF, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h15, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h00, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h6E, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    // ack frame with a bad checksum is dropped
    '{8'hAA, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'hAF, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h10, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h00, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE},
    '{8'h00, 1'b1, 3'd0, cfpu_pkg::KIND_ACK_BYTE}
  };

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [cfpu_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0]                     cfg_data_i;

  cfpu_rx_if rx_if ();
  cfpu_tx_if tx_if ();

  command_frame_parser_unit i_dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i,
    .rx_i (rx_if),
    .tx_o (tx_if)
  );

  always #5 clk_i = ~clk_i;

  // local copy of the limits and the parse state
  logic [7:0]   len_limit;
  logic [7:0]   fn_limit;
  parse_phase_e phase;
  logic [7:0]   bytes_left;
  logic [7:0]   run_sum;
  logic [7:0]   frame_fn;
  logic [7:0]   cmd_byte;
  logic         cmd_seen;

  // results caused by the latest byte, and results still owed by the block
  tx_item_t decoded_q[$];
  tx_item_t tx_expected_q[$];
  tx_item_t tx_want;
  tx_item_t tx_got;

  int unsigned bytes_sent   = 0;
  int unsigned results_owed = 0;
  int unsigned tx_checked   = 0;
  int unsigned mismatches   = 0;
  int unsigned stall_cycles = 0;
  bit          hold_tx      = 1'b0;
  bit          no_idle      = 1'b0;

  // advance the frame parser by one byte; results land in decoded_q
  function automatic void parse_rx_byte(input logic [7:0] b);
    logic [7:0] ack [7];
    logic [7:0] ack_sum;
    ack_sum = '0;
    decoded_q.delete();
    if (phase == PH_HUNT && b == cfpu_pkg::HDR_FIRST) begin
      phase    = PH_SYNC;
      run_sum  = b;
      cmd_seen = 1'b0;
      cmd_byte = '0;
    end else if (phase == PH_SYNC && b == cfpu_pkg::HDR_SECOND) begin
      phase   = PH_FUNC;
      run_sum = run_sum + b;
    end else if (phase == PH_FUNC && b < fn_limit) begin
      phase    = PH_LEN;
      frame_fn = b;
      run_sum  = run_sum + b;
    end else if (phase == PH_LEN && b < len_limit) begin
      run_sum    = run_sum + b;
      bytes_left = b;
      // an empty payload goes straight to the checksum
      phase      = (b == 8'd0) ? PH_CHECK : PH_PAYLOAD;
    end else if (phase == PH_PAYLOAD && bytes_left != 8'd0) begin
      if (!cmd_seen) begin
        cmd_byte = b;
        cmd_seen = 1'b1;
      end
      run_sum    = run_sum + b;
      bytes_left = bytes_left - 8'd1;
      if (bytes_left == 8'd0) phase = PH_CHECK;
    end else if (phase == PH_CHECK) begin
      phase = PH_HUNT;
      // with no payload the checksum byte doubles as the command byte
      if (!cmd_seen) begin
        cmd_byte = b;
        cmd_seen = 1'b1;
      end
      if (run_sum == b) begin
        if (frame_fn == cfpu_pkg::FN_COMMAND) begin
          if (cmd_byte == cfpu_pkg::CMD_READBACK) begin
            decoded_q.push_back(tx_item_t'{cfpu_pkg::KIND_READBACK, 8'h00, 1'b1});
          end else if (cmd_byte == cfpu_pkg::CMD_VERSION) begin
            decoded_q.push_back(tx_item_t'{cfpu_pkg::KIND_VERSION, 8'h00, 1'b1});
          end
        end else if (frame_fn inside {[cfpu_pkg::FN_ACK_LOW:cfpu_pkg::FN_ACK_HIGH]}) begin
          ack[0] = cfpu_pkg::ACK_HDR;
          ack[1] = cfpu_pkg::ACK_HDR;
          ack[2] = cfpu_pkg::ACK_ID;
          ack[3] = cfpu_pkg::ACK_LEN;
          ack[4] = frame_fn;
          ack[5] = run_sum;
          for (int i = 0; i < 6; i++) ack_sum = ack_sum + ack[i];
          ack[6] = ack_sum;
          for (int i = 0; i < 7; i++) begin
            decoded_q.push_back(tx_item_t'{cfpu_pkg::KIND_ACK_BYTE, ack[i], i == 6});
          end
        end
      end
    end else begin
      // mismatch: byte is dropped, not retried as a header
      phase = PH_HUNT;
    end
  endfunction

  // offer one byte on rx_i, with random gaps, and book its results once taken
  task automatic send_rx_byte(input logic [7:0] b, input logic typed,
                              input logic [2:0] n_typed, input logic [1:0] kind_typed);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(99) < 15) begin
      rx_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    parse_rx_byte(b);
    // hand-written rows override the local parser, which still tracks the state
    if (typed) begin
      decoded_q.delete();
      for (int i = 0; i < n_typed; i++) begin
        decoded_q.push_back(tx_item_t'{kind_typed, 8'h00, i == n_typed - 1});
      end
    end
    foreach (decoded_q[i]) tx_expected_q.push_back(decoded_q[i]);
    results_owed += decoded_q.size();
    bytes_sent++;
  endtask

  // stop offering bytes and wait until every owed result is out and the parser is quiet
  task automatic settle_block();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (tx_expected_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // write both limits while the block is quiet
  task automatic write_limits(input logic [7:0] new_len, input logic [7:0] new_fn);
    settle_block();
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= cfpu_pkg::CFG_LENGTH_LIMIT;
    cfg_data_i <= new_len;
    @(negedge clk_i);
    cfg_idx_i  <= cfpu_pkg::CFG_FUNCTION_LIMIT;
    cfg_data_i <= new_fn;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    len_limit = new_len;
    fn_limit  = new_fn;
  endtask

  // a run of good zero-length acknowledge frames, enough to fill the queue
  task automatic send_ack_frames(input int unsigned n_frames);
    logic [7:0] fn;
    logic [7:0] sum;
    for (int f = 0; f < n_frames; f++) begin
      fn  = cfpu_pkg::FN_ACK_LOW + 8'(f % 6);
      sum = cfpu_pkg::HDR_FIRST + cfpu_pkg::HDR_SECOND + fn;
      send_rx_byte(cfpu_pkg::HDR_FIRST, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE);
      send_rx_byte(cfpu_pkg::HDR_SECOND, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE);
      send_rx_byte(fn, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE);
      send_rx_byte(8'h00, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE);
      send_rx_byte(sum, 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE);
    end
  endtask

  // mostly well-formed frames with random content, plus noise and cut-off frames
  task automatic send_random_frames(input int unsigned n_bytes);
    logic [7:0]  frame_q[$];
    logic [7:0]  fn;
    logic [7:0]  len;
    logic [7:0]  sum;
    int unsigned start;
    int unsigned keep;
    start = bytes_sent;
    while (bytes_sent - start < n_bytes) begin
      frame_q.delete();
      if ($urandom_range(9) == 0) begin
        // line noise
        repeat ($urandom_range(1, 3)) frame_q.push_back(8'($urandom_range(255)));
      end else begin
        case ($urandom_range(9))
          0, 1, 2:    fn = cfpu_pkg::FN_COMMAND;
          3, 4, 5, 6: fn = cfpu_pkg::FN_ACK_LOW + 8'($urandom_range(5));
          // just outside the acknowledge range
          7:          fn = $urandom_range(1) ? cfpu_pkg::FN_ACK_LOW - 8'd1
                                             : cfpu_pkg::FN_ACK_HIGH + 8'd1;
          default:    fn = 8'($urandom_range(255));
        endcase
        // mostly short payloads, now and then one of up to 60 bytes, which can exceed the default length limit
        len = ($urandom_range(19) == 0) ? 8'($urandom_range(60)) : 8'($urandom_range(4));
        frame_q.push_back(cfpu_pkg::HDR_FIRST);
        frame_q.push_back(cfpu_pkg::HDR_SECOND);
        frame_q.push_back(fn);
        frame_q.push_back(len);
        for (int i = 0; i < len; i++) begin
          if (i == 0 && $urandom_range(9) < 7) begin
            frame_q.push_back($urandom_range(1) ? cfpu_pkg::CMD_READBACK
                                                : cfpu_pkg::CMD_VERSION);
          end else begin
            frame_q.push_back(8'($urandom_range(255)));
          end
        end
        sum = '0;
        foreach (frame_q[i]) sum = sum + frame_q[i];
        // corrupt one checksum bit now and then
        if ($urandom_range(99) < 15) sum = sum ^ 8'(1 << $urandom_range(7));
        frame_q.push_back(sum);
        // cut the frame short now and then
        if ($urandom_range(9) == 0) begin
          keep = $urandom_range(1, frame_q.size() - 1);
          while (frame_q.size() > keep) void'(frame_q.pop_back());
        end
      end
      foreach (frame_q[i]) send_rx_byte(frame_q[i], 1'b0, 3'd0, cfpu_pkg::KIND_ACK_BYTE);
    end
  endtask

  function automatic void note_mismatch(input string what, input tx_item_t want,
                                        input tx_item_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t %s: expected kind %0d byte %h last %0b, got kind %0d byte %h last %0b",
               $realtime, what, want.kind, want.tx_byte, want.last,
               got.kind, got.tx_byte, got.last);
    end
  endfunction

  // result sink: random back-pressure, one long hold-off when asked
  initial begin
    tx_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_tx) begin
        tx_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_tx = 1'b0;
      end else begin
        tx_if.ready <= no_idle || ($urandom_range(99) >= 15);
      end
    end
  end

  // compare each result transaction with the oldest one owed
  always @(posedge clk_i) begin
    if (rst_ni && tx_if.valid && tx_if.ready) begin
      tx_checked++;
      tx_got = tx_item_t'{tx_if.kind, tx_if.tx_byte, tx_if.last};
      if (tx_expected_q.size() == 0) begin
        note_mismatch("result with none owed", '0, tx_got);
      end else begin
        tx_want = tx_expected_q.pop_front();
        if (tx_want.kind !== tx_got.kind || tx_want.tx_byte !== tx_got.tx_byte ||
            tx_want.last !== tx_got.last) begin
          note_mismatch("result mismatch", tx_want, tx_got);
        end
      end
    end
  end

  // watchdog: too long without any transaction on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (rx_if.valid && rx_if.ready) || (tx_if.valid && tx_if.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles, %0d results still owed",
                 WATCHDOG_LIMIT, tx_expected_q.size());
        $display("command_frame_parser_unit test failed");
        $finish;
      end
    end
  end

  // main sequence
  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = cfpu_pkg::CFG_LENGTH_LIMIT;
    cfg_data_i    = '0;
    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    len_limit     = cfpu_pkg::LENGTH_LIMIT_RST;
    fn_limit      = cfpu_pkg::FUNCTION_LIMIT_RST;
    phase         = PH_HUNT;
    bytes_left    = '0;
    run_sum       = '0;
    frame_fn      = '0;
    cmd_byte      = '0;
    cmd_seen      = 1'b0;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    // directed frames at the reset limits
    foreach (FRAME_TABLE[r]) begin
      send_rx_byte(FRAME_TABLE[r].rx_byte, FRAME_TABLE[r].typed,
                   FRAME_TABLE[r].n_res, FRAME_TABLE[r].kind);
    end
    send_random_frames(BURST_BYTES);

    // zero limits: nothing gets past the function byte
    write_limits(8'd0, 8'd0);
    send_random_frames(BURST_BYTES);

    // arbitrary limits
    write_limits(8'($urandom_range(1, 254)), 8'($urandom_range(1, 254)));
    send_random_frames(BURST_BYTES);

    // tight limits around the ack range, no idling on either side
    no_idle = 1'b1;
    write_limits(8'd3, cfpu_pkg::FN_ACK_HIGH + 8'd1);
    send_random_frames(BURST_BYTES);
    no_idle = 1'b0;

    // full-scale limits; output held off while ack frames fill the queue and stall rx_i
    write_limits(8'd255, 8'd255);
    hold_tx = 1'b1;
    send_ack_frames(PRESSURE_FRAMES);
    send_random_frames(BURST_BYTES);

    settle_block();
    $display("sent %0d link bytes and checked %0d of %0d owed result transactions",
             bytes_sent, tx_checked, results_owed);
    $display("limits covered: reset, zero, random, tight and full scale, plus a long output stall");
    if (mismatches == 0) begin
      $display("command_frame_parser_unit test passed");
    end else begin
      $display("%0d result mismatches", mismatches);
      $display("command_frame_parser_unit test failed");
    end
    $finish;
  end

endmodule
